[rtl/gts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPS track statistics package
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int GTS_CORDIC_STEPS = 32;

  localparam int ANG_W      = 34;
  localparam int MUL_W      = 32;
  localparam int DIV_NW     = 59;
  localparam int DIV_DW     = 39;
  localparam int ATAN_IDX_W = 6;
  localparam int RADIUS_W   = 23;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;
  localparam logic [31:0] ONE_Q30      = 32'd1073741824;
  localparam int          UDEG_HALF    = 180000000;
  localparam int          UDEG_QUARTER = 90000000;
  localparam int          UDEG_FULL    = 360000000;
  localparam int          DAY_SECONDS  = 86400;
  localparam int          SPEED_MAX    = 1000000;
  localparam int          RADIUS_RST   = 6371000;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  function automatic logic [31:0] gts_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] a;
    a = '0;
    if (idx < ATAN_IDX_W'(32)) begin
      a = ATAN_Q30[idx[4:0]];
    end
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/gps_track_statistics.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPS track statistics
// Great-circle segment distance by the spherical law of cosines with CORDIC,
// and running track totals, extremes and speeds.
//
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_wr_en             cfg_wr_data (earth radius, meters)
// in       in         in_valid / in_ready   track point and time of day
// out      out        out_valid / out_ready running statistics
//
// An item that measures a segment uses the shared serial divider (three angle
// scalings, speed, time split, average), the serial multiplier and three
// rotations and one vectoring pass of the CORDIC unit; the speed division is
// skipped when its time step is zero, and the first point of a track uses the
// divider only, for the time split.
// Reset is synchronous and active low. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module gps_track_statistics
  import gts_pkg::*;
#(
  parameter int CORDIC_STEPS = GTS_CORDIC_STEPS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [RADIUS_W-1:0]  cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_start_track,
  input  wire logic signed [27:0]   in_latitude,
  input  wire logic signed [28:0]   in_longitude,
  input  wire logic signed [20:0]   in_elevation_cm,
  input  wire logic [4:0]           in_hour,
  input  wire logic [5:0]           in_minute,
  input  wire logic [5:0]           in_second,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [39:0]               out_total_distance_mm,
  output logic [20:0]               out_elapsed_hours,
  output logic [5:0]                out_elapsed_minutes,
  output logic [5:0]                out_elapsed_secs,
  output logic [19:0]               out_max_speed,
  output logic [19:0]               out_avg_speed,
  output logic [30:0]               out_gain_cm,
  output logic signed [31:0]        out_loss_cm,
  output logic signed [20:0]        out_highest_cm,
  output logic signed [20:0]        out_lowest_cm
);

  localparam int IT_W = $clog2(CORDIC_STEPS);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RED    = 5'd1;
  localparam logic [4:0] S_FOLD   = 5'd2;
  localparam logic [4:0] S_FOLD2  = 5'd3;
  localparam logic [4:0] S_QMUL   = 5'd4;
  localparam logic [4:0] S_QDIV   = 5'd5;
  localparam logic [4:0] S_ROT    = 5'd6;
  localparam logic [4:0] S_ROTEND = 5'd7;
  localparam logic [4:0] S_V1     = 5'd8;
  localparam logic [4:0] S_V1W    = 5'd9;
  localparam logic [4:0] S_V2W    = 5'd10;
  localparam logic [4:0] S_V3W    = 5'd11;
  localparam logic [4:0] S_CLAMP  = 5'd12;
  localparam logic [4:0] S_SQW    = 5'd13;
  localparam logic [4:0] S_SQRT   = 5'd14;
  localparam logic [4:0] S_VEC    = 5'd15;
  localparam logic [4:0] S_ACOS   = 5'd16;
  localparam logic [4:0] S_DMUL   = 5'd17;
  localparam logic [4:0] S_ACC    = 5'd18;
  localparam logic [4:0] S_SPD    = 5'd19;
  localparam logic [4:0] S_EXT    = 5'd20;
  localparam logic [4:0] S_HRS    = 5'd21;
  localparam logic [4:0] S_MIN    = 5'd22;
  localparam logic [4:0] S_AVG    = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_D = 2'd2;

  localparam logic signed [30:0] A_FULL = 31'(UDEG_FULL);
  localparam logic signed [30:0] A_HALF = 31'(UDEG_HALF);
  localparam logic signed [30:0] A_QTR  = 31'(UDEG_QUARTER);
  localparam logic signed [34:0] V_ONE  = 35'(ONE_Q30);
  localparam logic signed [ANG_W-1:0] X_INIT = ANG_W'(GAIN_INV_Q30);
  localparam logic [19:0] SPEED_CAP = 20'(SPEED_MAX);
  localparam logic signed [20:0] ELEV_NEG = 21'sh100000;
  localparam logic signed [20:0] ELEV_POS = 21'sh0FFFFF;
  localparam logic signed [32:0] DESC_MIN = -33'sd2147483647;

  function automatic logic [MUL_W-1:0] mag_of(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W-1:0] m;
    m = (v < 0) ? -v : v;
    return m[MUL_W-1:0];
  endfunction

  function automatic logic [19:0] cap_speed(input logic [DIV_NW-1:0] q);
    logic [19:0] s;
    s = (q > DIV_NW'(SPEED_MAX)) ? SPEED_CAP : q[19:0];
    return s;
  endfunction

  logic [4:0]              state_r;
  logic [RADIUS_W-1:0]     radius_r;
  logic                    have_prev_r;
  logic signed [27:0]      prev_lat_r, lat_r;
  logic signed [28:0]      prev_lon_r, lon_r;
  logic signed [20:0]      prev_elev_r, elev_r;
  logic [16:0]             prev_tod_r, tod_r;
  logic [39:0]             dist_sum_r;
  logic [31:0]             secs_sum_r;
  logic [19:0]             peak_r;
  logic [30:0]             climb_r;
  logic signed [31:0]      descent_r;
  logic signed [20:0]      elev_max_r, elev_min_r;

  logic signed [30:0]      ang_r;
  logic                    flip_r, neg_r, vneg_r;
  logic [1:0]              sel_r;
  logic signed [ANG_W-1:0] x_r, y_r, z_r;
  logic [IT_W-1:0]         it_r;
  logic signed [ANG_W-1:0] ca_r, sa_r, cb_r, sb_r, cd_r;
  logic signed [34:0]      v_r;
  logic [30:0]             u_r;
  logic [60:0]             sq_n_r, sq_res_r, sq_bit_r;
  logic [34:0]             mm_r;
  logic [20:0]             hrs_r;
  logic [5:0]              min_r, sec_r;
  logic [19:0]             avg_r;

  logic                    mul_start_r, mul_sgn_r, mul_done;
  logic [MUL_W-1:0]        mul_a_r, mul_b_r;
  logic [2*MUL_W-1:0]      mul_p;
  logic                    div_start_r, div_done;
  logic [DIV_NW-1:0]       div_n_r, div_q;
  logic [DIV_DW-1:0]       div_d_r, div_rem;

  logic                    out_valid_r;
  logic [39:0]             o_dist_r;
  logic [20:0]             o_hrs_r;
  logic [5:0]              o_min_r, o_sec_r;
  logic [19:0]             o_peak_r, o_avg_r;
  logic [30:0]             o_climb_r;
  logic signed [31:0]      o_desc_r;
  logic signed [20:0]      o_max_r, o_min_elev_r;

  gts_mul #(.W(MUL_W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (mul_a_r),
    .b       (mul_b_r),
    .done    (mul_done),
    .product (mul_p)
  );

  gts_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (div_n_r),
    .divisor   (div_d_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // CORDIC step, rotation or vectoring.
  logic signed [ANG_W-1:0] tx, ty, step_a, x_nxt, y_nxt, z_nxt;
  assign tx     = x_r >>> it_r;
  assign ty     = y_r >>> it_r;
  assign step_a = $signed({2'b00, gts_atan(ATAN_IDX_W'(it_r))});

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (state_r == S_ROT) begin
      if (!z_r[ANG_W-1]) begin
        x_nxt = x_r - ty; y_nxt = y_r + tx; z_nxt = z_r - step_a;
      end else begin
        x_nxt = x_r + ty; y_nxt = y_r - tx; z_nxt = z_r + step_a;
      end
    end else if (y_r > 0) begin
      x_nxt = x_r + ty; y_nxt = y_r - tx; z_nxt = z_r + step_a;
    end else if (y_r < 0) begin
      x_nxt = x_r - ty; y_nxt = y_r + tx; z_nxt = z_r - step_a;
    end
  end

  // Quadrant fold of the reduced angle.
  logic signed [30:0] fold_a, fold_abs;
  logic               fold_flip;
  always_comb begin
    fold_a    = ang_r;
    fold_flip = 1'b0;
    if (ang_r > A_QTR) begin
      fold_a    = A_HALF - ang_r;
      fold_flip = 1'b1;
    end else if (ang_r < -A_QTR) begin
      fold_a    = -A_HALF - ang_r;
      fold_flip = 1'b1;
    end
    fold_abs = (fold_a < 0) ? -fold_a : fold_a;
  end

  // Signed product scaled back to Q4.30.
  logic signed [2*MUL_W-1:0] prod_s, prod_sh;
  logic signed [ANG_W-1:0]   prod_q;
  assign prod_s  = mul_sgn_r ? -$signed(mul_p) : $signed(mul_p);
  assign prod_sh = prod_s >>> 30;
  assign prod_q  = prod_sh[ANG_W-1:0];

  logic signed [34:0] v_cl;
  assign v_cl = (v_r > V_ONE) ? V_ONE : ((v_r < -V_ONE) ? -V_ONE : v_r);

  logic [61:0] sq_trial;
  logic        sq_ge;
  logic [60:0] sq_res_nxt;
  assign sq_trial   = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign sq_ge      = {1'b0, sq_n_r} >= sq_trial;
  assign sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);

  logic signed [ANG_W-1:0] z_cl;
  logic [31:0]             acos_ang;
  assign z_cl     = (z_r < 0) ? '0 : z_r;
  assign acos_ang = vneg_r ? (PI_Q30 - z_cl[31:0]) : z_cl[31:0];

  logic [34:0] mm_hi, mm_val;
  logic [39:0] mm_fr;
  assign mm_hi  = 35'(mul_p[54:30]) * 35'd1000;
  assign mm_fr  = 40'(mul_p[29:0]) * 40'd1000 + 40'd536870912;
  assign mm_val = mm_hi + 35'(mm_fr[39:30]);

  logic [40:0]        dist_add;
  logic signed [18:0] dt0, dt1;
  logic [16:0]        dt_val;
  logic [32:0]        secs_add;
  logic signed [21:0] de;
  logic [31:0]        climb_add;
  logic signed [32:0] desc_add;
  assign dist_add  = {1'b0, dist_sum_r} + 41'(mm_r);
  assign dt0       = $signed({2'b00, tod_r}) - $signed({2'b00, prev_tod_r});
  assign dt1       = (dt0 < 0) ? dt0 + 19'(DAY_SECONDS) : dt0;
  assign dt_val    = (dt1 < 0) ? '0 : dt1[16:0];
  assign secs_add  = {1'b0, secs_sum_r} + 33'(dt_val);
  assign de        = 22'(elev_r) - 22'(prev_elev_r);
  assign climb_add = {1'b0, climb_r} + 32'(de[20:0]);
  assign desc_add  = 33'(descent_r) + 33'(de);

  logic [16:0] in_tod;
  assign in_tod = 17'(in_hour) * 17'd3600 + 17'(in_minute) * 17'd60 + 17'(in_second);

  logic [19:0] spd_q;
  assign spd_q = cap_speed(div_q);

  logic signed [ANG_W-1:0] cos_out;
  assign cos_out = flip_r ? -x_r : x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_W'(RADIUS_RST);
      have_prev_r <= 1'b0;
      prev_lat_r  <= '0;
      prev_lon_r  <= '0;
      prev_elev_r <= '0;
      prev_tod_r  <= '0;
      dist_sum_r  <= '0;
      secs_sum_r  <= '0;
      peak_r      <= '0;
      climb_r     <= '0;
      descent_r   <= '0;
      elev_max_r  <= ELEV_NEG;
      elev_min_r  <= ELEV_POS;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lat_r  <= in_latitude;
            lon_r  <= in_longitude;
            elev_r <= in_elevation_cm;
            tod_r  <= in_tod;
            sel_r  <= SEL_A;
            ang_r  <= 31'(prev_lat_r);
            if (in_start_track) begin
              have_prev_r <= 1'b0;
              dist_sum_r  <= '0;
              secs_sum_r  <= '0;
              peak_r      <= '0;
              climb_r     <= '0;
              descent_r   <= '0;
              elev_max_r  <= ELEV_NEG;
              elev_min_r  <= ELEV_POS;
            end
            state_r <= (!in_start_track && have_prev_r) ? S_RED : S_EXT;
          end
        end
        S_RED: begin
          if (ang_r < 0) begin
            ang_r <= ang_r + A_FULL;
          end else if (ang_r >= A_FULL) begin
            ang_r <= ang_r - A_FULL;
          end else begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (ang_r > A_HALF) begin
            ang_r <= ang_r - A_FULL;
          end
          state_r <= S_FOLD2;
        end
        S_FOLD2: begin
          flip_r      <= fold_flip;
          neg_r       <= fold_a[30];
          mul_a_r     <= MUL_W'($unsigned(fold_abs));
          mul_b_r     <= PI_Q30;
          mul_sgn_r   <= 1'b0;
          mul_start_r <= 1'b1;
          state_r     <= S_QMUL;
        end
        S_QMUL: begin
          if (mul_done) begin
            div_n_r     <= DIV_NW'(mul_p) + DIV_NW'(UDEG_QUARTER);
            div_d_r     <= DIV_DW'(UDEG_HALF);
            div_start_r <= 1'b1;
            state_r     <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_done) begin
            z_r     <= neg_r ? -$signed(ANG_W'(div_q)) : $signed(ANG_W'(div_q));
            x_r     <= X_INIT;
            y_r     <= '0;
            it_r    <= '0;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          x_r  <= x_nxt;
          y_r  <= y_nxt;
          z_r  <= z_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_ROTEND;
          end
        end
        S_ROTEND: begin
          unique case (sel_r)
            SEL_A: begin
              ca_r    <= cos_out;
              sa_r    <= y_r;
              ang_r   <= 31'(lat_r);
              sel_r   <= SEL_B;
              state_r <= S_RED;
            end
            SEL_B: begin
              cb_r    <= cos_out;
              sb_r    <= y_r;
              ang_r   <= 31'(lon_r) - 31'(prev_lon_r);
              sel_r   <= SEL_D;
              state_r <= S_RED;
            end
            default: begin
              cd_r    <= cos_out;
              state_r <= S_V1;
            end
          endcase
        end
        S_V1: begin
          mul_a_r     <= mag_of(sa_r);
          mul_b_r     <= mag_of(sb_r);
          mul_sgn_r   <= sa_r[ANG_W-1] ^ sb_r[ANG_W-1];
          mul_start_r <= 1'b1;
          state_r     <= S_V1W;
        end
        S_V1W: begin
          if (mul_done) begin
            v_r         <= 35'(prod_q);
            mul_a_r     <= mag_of(ca_r);
            mul_b_r     <= mag_of(cb_r);
            mul_sgn_r   <= ca_r[ANG_W-1] ^ cb_r[ANG_W-1];
            mul_start_r <= 1'b1;
            state_r     <= S_V2W;
          end
        end
        S_V2W: begin
          if (mul_done) begin
            mul_a_r     <= mag_of(prod_q);
            mul_b_r     <= mag_of(cd_r);
            mul_sgn_r   <= prod_q[ANG_W-1] ^ cd_r[ANG_W-1];
            mul_start_r <= 1'b1;
            state_r     <= S_V3W;
          end
        end
        S_V3W: begin
          if (mul_done) begin
            v_r     <= v_r + 35'(prod_q);
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          vneg_r      <= v_cl[34];
          u_r         <= v_cl[34] ? 31'(-v_cl) : 31'(v_cl);
          mul_a_r     <= v_cl[34] ? MUL_W'(-v_cl) : MUL_W'(v_cl);
          mul_b_r     <= v_cl[34] ? MUL_W'(-v_cl) : MUL_W'(v_cl);
          mul_sgn_r   <= 1'b0;
          mul_start_r <= 1'b1;
          state_r     <= S_SQW;
        end
        S_SQW: begin
          if (mul_done) begin
            sq_n_r   <= (61'd1 << 60) - mul_p[60:0];
            sq_res_r <= '0;
            sq_bit_r <= 61'd1 << 60;
            state_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n_r <= sq_n_r - sq_trial[60:0];
          end
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            x_r     <= ANG_W'(u_r);
            y_r     <= ANG_W'(sq_res_nxt);
            z_r     <= '0;
            it_r    <= '0;
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          x_r  <= x_nxt;
          y_r  <= y_nxt;
          z_r  <= z_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_ACOS;
          end
        end
        S_ACOS: begin
          mul_a_r     <= acos_ang;
          mul_b_r     <= MUL_W'(radius_r);
          mul_sgn_r   <= 1'b0;
          mul_start_r <= 1'b1;
          state_r     <= S_DMUL;
        end
        S_DMUL: begin
          if (mul_done) begin
            mm_r    <= mm_val;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          dist_sum_r <= dist_add[40] ? '1 : dist_add[39:0];
          secs_sum_r <= secs_add[32] ? '1 : secs_add[31:0];
          if (de > 0) begin
            climb_r <= climb_add[31] ? '1 : climb_add[30:0];
          end else if (de < 0) begin
            descent_r <= (desc_add < DESC_MIN) ? 32'(DESC_MIN) : desc_add[31:0];
          end
          if (dt_val != '0) begin
            div_n_r     <= DIV_NW'(mm_r) * DIV_NW'(36) + DIV_NW'(dt_val) * DIV_NW'(50);
            div_d_r     <= DIV_DW'(dt_val) * DIV_DW'(100);
            div_start_r <= 1'b1;
            state_r     <= S_SPD;
          end else begin
            state_r <= S_EXT;
          end
        end
        S_SPD: begin
          if (div_done) begin
            if (spd_q > peak_r) begin
              peak_r <= spd_q;
            end
            state_r <= S_EXT;
          end
        end
        S_EXT: begin
          if (elev_r > elev_max_r) begin
            elev_max_r <= elev_r;
          end
          if (elev_r < elev_min_r) begin
            elev_min_r <= elev_r;
          end
          prev_lat_r  <= lat_r;
          prev_lon_r  <= lon_r;
          prev_elev_r <= elev_r;
          prev_tod_r  <= tod_r;
          have_prev_r <= 1'b1;
          div_n_r     <= DIV_NW'(secs_sum_r);
          div_d_r     <= DIV_DW'(3600);
          div_start_r <= 1'b1;
          state_r     <= S_HRS;
        end
        S_HRS: begin
          if (div_done) begin
            hrs_r       <= div_q[20:0];
            div_n_r     <= DIV_NW'(div_rem);
            div_d_r     <= DIV_DW'(60);
            div_start_r <= 1'b1;
            state_r     <= S_MIN;
          end
        end
        S_MIN: begin
          if (div_done) begin
            min_r <= div_q[5:0];
            sec_r <= div_rem[5:0];
            if (secs_sum_r == '0) begin
              avg_r   <= '0;
              state_r <= S_DONE;
            end else begin
              div_n_r <= DIV_NW'(dist_sum_r) * DIV_NW'(36) +
                         DIV_NW'(secs_sum_r) * DIV_NW'(50);
              div_d_r     <= DIV_DW'(secs_sum_r) * DIV_DW'(100);
              div_start_r <= 1'b1;
              state_r     <= S_AVG;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg_r   <= spd_q;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            o_dist_r     <= dist_sum_r;
            o_hrs_r      <= hrs_r;
            o_min_r      <= min_r;
            o_sec_r      <= sec_r;
            o_peak_r     <= peak_r;
            o_avg_r      <= avg_r;
            o_climb_r    <= climb_r;
            o_desc_r     <= descent_r;
            o_max_r      <= elev_max_r;
            o_min_elev_r <= elev_min_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_total_distance_mm = o_dist_r;
  assign out_elapsed_hours     = o_hrs_r;
  assign out_elapsed_minutes   = o_min_r;
  assign out_elapsed_secs      = o_sec_r;
  assign out_max_speed         = o_peak_r;
  assign out_avg_speed         = o_avg_r;
  assign out_gain_cm           = o_climb_r;
  assign out_loss_cm           = o_desc_r;
  assign out_highest_cm        = o_max_r;
  assign out_lowest_cm         = o_min_elev_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    have_prev_r |-> elev_max_r >= elev_min_r)
    else $error("elevation extremes inverted on a started track");

  a_peak_cap: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= SPEED_CAP)
    else $error("peak speed above its cap");

  a_loss_sign: assert property (@(posedge clk) disable iff (!rst_n)
    descent_r <= 0)
    else $error("elevation loss became positive");

endmodule
`default_nettype wire

[rtl/gts_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gts_mul
  import gts_pkg::*;
#(
  parameter int W = MUL_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic [2*W-1:0]      product
);

  localparam int CW = $clog2(W);

  logic [W-1:0]   a_r;
  logic [2*W-1:0] p_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W:0]     sum;

  assign sum = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, a_r} : {(W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        p_r    <= {{W{1'b0}}, b};
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= {sum, p_r[W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule
`default_nettype wire

[rtl/gts_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gts_div
  import gts_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DW-1:0]  divisor,
  output logic                done,
  output logic [NW-1:0]       quotient,
  output logic [DW-1:0]       remainder
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          ge;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[dv/gps_track_statistics_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS track statistics testbench
// A directed table of track points is followed by random tracks and noise
// under several sphere radii. Each result is checked against stats typed in
// the table or a built-in CORDIC model of distance and running track totals.
// ----------------------------------------------------------------------------
module gps_track_statistics_tb
  import gts_pkg::*;
();

  typedef struct {
    bit                 start;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic signed [20:0] elev;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } point_t;

  typedef struct {
    logic [39:0]        dist_mm;
    logic [20:0]        hours;
    logic [5:0]         minutes;
    logic [5:0]         secs;
    logic [19:0]        max_spd;
    logic [19:0]        avg_spd;
    logic [30:0]        gain;
    logic signed [31:0] loss;
    logic signed [20:0] highest;
    logic signed [20:0] lowest;
  } stats_t;

  typedef struct {
    point_t pt;
    bit     typed;
    stats_t stats;
  } row_t;

  localparam longint ONE   = 64'd1073741824;
  localparam longint PI    = 64'd3373259426;
  localparam longint DMAX  = 64'hFF_FFFF_FFFF;
  localparam longint SMAX  = 64'hFFFF_FFFF;
  localparam longint CLMAX = 64'd2147483647;
  localparam longint DSMIN = -64'sd2147483647;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [RADIUS_W-1:0]  cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_track = 1'b0;
  logic signed [27:0]   in_latitude = '0;
  logic signed [28:0]   in_longitude = '0;
  logic signed [20:0]   in_elevation_cm = '0;
  logic [4:0]           in_hour = '0;
  logic [5:0]           in_minute = '0;
  logic [5:0]           in_second = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [39:0]          out_total_distance_mm;
  logic [20:0]          out_elapsed_hours;
  logic [5:0]           out_elapsed_minutes;
  logic [5:0]           out_elapsed_secs;
  logic [19:0]          out_max_speed;
  logic [19:0]          out_avg_speed;
  logic [30:0]          out_gain_cm;
  logic signed [31:0]   out_loss_cm;
  logic signed [20:0]   out_highest_cm;
  logic signed [20:0]   out_lowest_cm;

  gps_track_statistics i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_track       (in_start_track),
    .in_latitude          (in_latitude),
    .in_longitude         (in_longitude),
    .in_elevation_cm      (in_elevation_cm),
    .in_hour              (in_hour),
    .in_minute            (in_minute),
    .in_second            (in_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_total_distance_mm(out_total_distance_mm),
    .out_elapsed_hours    (out_elapsed_hours),
    .out_elapsed_minutes  (out_elapsed_minutes),
    .out_elapsed_secs     (out_elapsed_secs),
    .out_max_speed        (out_max_speed),
    .out_avg_speed        (out_avg_speed),
    .out_gain_cm          (out_gain_cm),
    .out_loss_cm          (out_loss_cm),
    .out_highest_cm       (out_highest_cm),
    .out_lowest_cm        (out_lowest_cm)
  );

  always #10 clk = ~clk;

  // Track state of the model.
  longint radius_m = RADIUS_RST;
  bit     tracking = 1'b0;
  longint last_lat = 0, last_lon = 0, last_elev = 0, last_tod = 0;
  longint dist_sum = 0, secs_sum = 0, peak_spd = 0, climb = 0, descent = 0;
  longint elev_hi = -1048576, elev_lo = 1048575;

  stats_t pending_stats[$];
  int     fail_count = 0;
  int     result_count = 0;
  int     item_count = 0;
  bit     idle_on = 1'b1;
  int     out_hold = 0;

  function automatic void cordic_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, tx, ty, a;
    x = GAIN_INV_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < GTS_CORDIC_STEPS; i++) begin
      tx = x >>> i;
      ty = y >>> i;
      a = (i < 32) ? longint'(ATAN_Q30[i]) : 0;
      if (z >= 0) begin
        x -= ty; y += tx; z -= a;
      end else begin
        x += ty; y -= tx; z += a;
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic void udeg_sincos(input longint u, output longint c, output longint s);
    longint a, mag, q;
    bit flip;
    flip = 1'b0;
    a = u % 360000000;
    if (a < 0) a += 360000000;
    if (a > 180000000) a -= 360000000;
    if (a > 90000000) begin
      a = 180000000 - a; flip = 1'b1;
    end else if (a < -90000000) begin
      a = -180000000 - a; flip = 1'b1;
    end
    mag = (a < 0) ? -a : a;
    q = (mag * PI + 90000000) / 180000000;
    if (a < 0) q = -q;
    cordic_sincos(q, c, s);
    if (flip) c = -c;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arc_cosine(input longint v);
    longint u, x, y, z, tx, ty, a;
    z = 0;
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    u = (v < 0) ? -v : v;
    x = u;
    y = int_sqrt((64'd1 << 60) - u * u);
    for (int i = 0; i < GTS_CORDIC_STEPS; i++) begin
      tx = x >>> i;
      ty = y >>> i;
      a = (i < 32) ? longint'(ATAN_Q30[i]) : 0;
      if (y > 0) begin
        x += ty; y -= tx; z += a;
      end else if (y < 0) begin
        x -= ty; y += tx; z -= a;
      end
    end
    if (z < 0) z = 0;
    return (v < 0) ? PI - z : z;
  endfunction

  function automatic longint segment_length_mm(input longint lat, input longint lon);
    longint ca, sa, cb, sb, cd, sd, v, q;
    udeg_sincos(last_lat, ca, sa);
    udeg_sincos(lat, cb, sb);
    udeg_sincos(lon - last_lon, cd, sd);
    v = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
    q = arc_cosine(v) * radius_m;
    return (q >> 30) * 1000 + (((q & (ONE - 1)) * 1000 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint speed_kmh100(input longint mm, input longint s);
    longint v;
    if (s == 0) return 0;
    v = (mm * 36 + s * 50) / (s * 100);
    return (v > 1000000) ? 1000000 : v;
  endfunction

  function automatic stats_t track_update(input point_t p);
    longint lat, lon, elev, tod, mm, dt, de;
    stats_t r;
    lat = p.lat;
    lon = p.lon;
    elev = p.elev;
    tod = longint'(p.hour) * 3600 + longint'(p.minute) * 60 + longint'(p.second);
    if (p.start) begin
      tracking = 1'b0;
      dist_sum = 0; secs_sum = 0; peak_spd = 0; climb = 0; descent = 0;
      elev_hi = -1048576;
      elev_lo = 1048575;
    end
    if (tracking) begin
      mm = segment_length_mm(lat, lon);
      dt = tod - last_tod;
      de = elev - last_elev;
      dist_sum = (dist_sum + mm > DMAX) ? DMAX : dist_sum + mm;
      if (dt < 0) dt += DAY_SECONDS;
      if (dt < 0) dt = 0;
      secs_sum += dt;
      if (secs_sum > SMAX) secs_sum = SMAX;
      if (dt > 0 && speed_kmh100(mm, dt) > peak_spd) peak_spd = speed_kmh100(mm, dt);
      if (de > 0) begin
        climb += de;
        if (climb > CLMAX) climb = CLMAX;
      end else if (de < 0) begin
        descent += de;
        if (descent < DSMIN) descent = DSMIN;
      end
    end
    if (elev > elev_hi) elev_hi = elev;
    if (elev < elev_lo) elev_lo = elev;
    last_lat = lat;
    last_lon = lon;
    last_elev = elev;
    last_tod = tod;
    tracking = 1'b1;
    r.dist_mm = dist_sum[39:0];
    r.hours = 21'(secs_sum / 3600);
    r.minutes = 6'((secs_sum % 3600) / 60);
    r.secs = 6'(secs_sum % 60);
    r.max_spd = peak_spd[19:0];
    r.avg_spd = 20'(speed_kmh100(dist_sum, secs_sum));
    r.gain = climb[30:0];
    r.loss = descent[31:0];
    r.highest = elev_hi[20:0];
    r.lowest = elev_lo[20:0];
    return r;
  endfunction

  function automatic stats_t first_point(input longint elev);
    stats_t r;
    r = '{default: '0};
    r.highest = elev[20:0];
    r.lowest = elev[20:0];
    return r;
  endfunction

  function automatic point_t mk_point(input bit st, input longint lat, input longint lon,
                                      input longint elev, input int h, input int m,
                                      input int s);
    point_t p;
    p.start = st;
    p.lat = lat[27:0];
    p.lon = lon[28:0];
    p.elev = elev[20:0];
    p.hour = h[4:0];
    p.minute = m[5:0];
    p.second = s[5:0];
    return p;
  endfunction

  task automatic send_point(input point_t p, input bit typed, input stats_t typed_stats);
    stats_t model;
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_track <= p.start;
    in_latitude <= p.lat;
    in_longitude <= p.lon;
    in_elevation_cm <= p.elev;
    in_hour <= p.hour;
    in_minute <= p.minute;
    in_second <= p.second;
    do @(posedge clk); while (!in_ready);
    model = track_update(p);
    pending_stats.push_back(typed ? typed_stats : model);
    item_count++;
  endtask

  task automatic set_radius(input longint r);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r[22:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_m = r & 64'h7FFFFF;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_count++;
        if (pending_stats.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          stats_t e;
          e = pending_stats.pop_front();
          check_field("total_distance_mm", e.dist_mm, out_total_distance_mm);
          check_field("elapsed_hours", e.hours, out_elapsed_hours);
          check_field("elapsed_minutes", e.minutes, out_elapsed_minutes);
          check_field("elapsed_secs", e.secs, out_elapsed_secs);
          check_field("max_speed", e.max_spd, out_max_speed);
          check_field("avg_speed", e.avg_spd, out_avg_speed);
          check_field("gain_cm", e.gain, out_gain_cm);
          check_field("loss_cm", e.loss, out_loss_cm);
          check_field("highest_cm", e.highest, out_highest_cm);
          check_field("lowest_cm", e.lowest, out_lowest_cm);
        end
        out_hold = idle_on ? $urandom_range(0, 15) : 0;
        out_ready <= (out_hold == 0);
      end else if (out_hold > 0) begin
        out_hold--;
        out_ready <= (out_hold == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("gps_track_statistics: mismatch");
    $finish;
  end

  initial begin
    row_t   rows[$];
    point_t p;
    stats_t none;
    longint radii[5];
    longint lat, lon, elev;
    int     tod, sel;

    none = '{default: '0};
    radii = '{64'd6300000, 64'd6400000, 64'h7FFFFF, 64'd0, 64'd6350000};

    rows.push_back('{mk_point(0, 90000000, 180000000, 900000, 12, 0, 0), 1,
                     first_point(900000)});
    rows.push_back('{mk_point(0, -90000000, -180000000, -50000, 12, 0, 0), 0, none});
    rows.push_back('{mk_point(0, -90000000, -180000000, -50000, 12, 0, 10), 0, none});
    rows.push_back('{mk_point(0, -89000000, 179000000, 1000, 0, 0, 5), 0, none});
    rows.push_back('{mk_point(1, 0, 0, 0, 23, 59, 59), 1, first_point(0)});
    rows.push_back('{mk_point(0, 1000, 1000, 250, 0, 0, 1), 0, none});
    rows.push_back('{mk_point(0, 2000, 1500, -300, 0, 0, 2), 0, none});
    rows.push_back('{mk_point(0, 134217727, -268435456, 1048575, 31, 63, 63), 0, none});
    rows.push_back('{mk_point(0, -134217728, 268435455, -1048576, 0, 0, 0), 0, none});
    rows.push_back('{mk_point(0, 45000000, 90000000, 500, 0, 0, 30), 0, none});
    rows.push_back('{mk_point(0, 45000000, 90000000, 500, 0, 0, 30), 0, none});
    rows.push_back('{mk_point(0, 0, 180000000, 100, 0, 1, 0), 0, none});
    rows.push_back('{mk_point(1, -1048576, 0, -1048576, 5, 30, 0), 1,
                     first_point(-1048576)});
    rows.push_back('{mk_point(0, 0, 0, 1048575, 5, 30, 1), 0, none});
    rows.push_back('{mk_point(0, 90000000, 0, -50000, 5, 30, 2), 0, none});
    rows.push_back('{mk_point(0, -90000000, 0, 900000, 5, 31, 2), 0, none});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].stats);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_radius(radii[ph - 1]);
      lat = 0; lon = 0; elev = 0; tod = 0;
      for (int n = 0; n < 90; n++) begin
        if (n % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (ph == 3 && n < 50) begin
          lon = (n % 2) ? 180000000 : 0;
          tod = (tod + 1) % DAY_SECONDS;
          p = mk_point(n == 0, 0, lon, 0, tod / 3600, (tod / 60) % 60, tod % 60);
        end else if (sel < 10) begin
          p.start = 1'($urandom_range(0, 1));
          p.lat = 28'($urandom());
          p.lon = 29'($urandom());
          p.elev = 21'($urandom());
          p.hour = 5'($urandom());
          p.minute = 6'($urandom());
          p.second = 6'($urandom());
        end else begin
          lat += $signed($urandom_range(0, 40000)) - 20000;
          lon += $signed($urandom_range(0, 40000)) - 20000;
          elev += $signed($urandom_range(0, 4000)) - 2000;
          if (lat > 90000000) lat = 90000000;
          if (lat < -90000000) lat = -90000000;
          if (elev > 900000) elev = 900000;
          if (elev < -50000) elev = -50000;
          tod = (tod + $urandom_range(0, 30)) % DAY_SECONDS;
          p = mk_point(sel < 15, lat, lon, elev, tod / 3600, (tod / 60) % 60, tod % 60);
        end
        send_point(p, 0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d track points over six sphere radii; %0d results checked.",
             item_count, result_count);
    if (fail_count == 0) begin
      $display("gps_track_statistics: match");
    end else begin
      $display("gps_track_statistics: mismatch");
    end
    $finish;
  end

endmodule

[gps_track_statistics.f]
rtl/gts_pkg.sv
rtl/gts_mul.sv
rtl/gts_div.sv
rtl/gps_track_statistics.sv
dv/gps_track_statistics_tb.sv
